// ===== hdl/ordered_multiset_neighbor_query_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ORDERED_MULTISET_NEIGHBOR_QUERY_MACROS_SVH
`define ORDERED_MULTISET_NEIGHBOR_QUERY_MACROS_SVH
`ifndef SYNTH
`define OMNQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("omnq: invariant violated");
`define OMNQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("omnq: next-cycle check violated");
`else
`define OMNQ_ASSERT(lbl, prop)
`define OMNQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/omnq_pkg.sv =====
`default_nettype none
package omnq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 20;
  localparam int COUNT_BITS_DEF = 16;

  // reported neighbor values and register data
  localparam int VAL_W     = 22;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MISS_BELOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_ABOVE = 1'd1;

  localparam logic [VAL_W-1:0] MISS_BELOW_RST = 22'h3FFFFF;
  localparam logic [VAL_W-1:0] MISS_ABOVE_RST = 22'd100001;

  // update applied to every cell when a request completes
  typedef struct packed {
    logic ins;  // insert new key at its sorted position, shift upper part right
    logic inc;  // matching cell counts up, saturating
    logic dec;  // matching cell counts down
    logic del;  // matching cell leaves, upper part shifts left
    logic clr;  // drop every entry
  } cell_op_t;

endpackage
`default_nettype wire

// ===== hdl/omnq_cell.sv =====
`default_nettype none
module omnq_cell import omnq_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmp_en_i,
  input  wire logic [KEY_BITS-1:0]   cmp_key_i,
  input  wire logic                  upd_en_i,
  input  wire cell_op_t              op_i,
  input  wire logic [KEY_BITS-1:0]   ins_key_i,
  // left (lower) neighbor
  input  wire logic                  l_lt_i,
  input  wire logic                  l_gt_i,
  input  wire logic                  l_valid_i,
  input  wire logic [KEY_BITS-1:0]   l_key_i,
  input  wire logic [COUNT_BITS-1:0] l_cnt_i,
  // right (upper) neighbor
  input  wire logic                  r_lt_i,
  input  wire logic                  r_valid_i,
  input  wire logic [KEY_BITS-1:0]   r_key_i,
  input  wire logic [COUNT_BITS-1:0] r_cnt_i,
  // own state
  output logic                       valid_o,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [COUNT_BITS-1:0]      cnt_o,
  output logic                       lt_o,
  output logic                       gt_o,
  output logic                       eq_o,
  output logic                       sel_below_o,
  output logic                       sel_above_o,
  output logic                       cnt_one_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  lt_q, gt_q, eq_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    if (op_i.clr) begin
      valid_d = 1'b0;
    end else if (op_i.inc && eq_q) begin
      cnt_d = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_ONE;
    end else if (op_i.dec && eq_q) begin
      cnt_d = cnt_q - CNT_ONE;
    end else if (op_i.ins && !lt_q) begin
      if (l_lt_i) begin
        valid_d = 1'b1;
        key_d   = ins_key_i;
        cnt_d   = CNT_ONE;
      end else begin
        valid_d = l_valid_i;
        key_d   = l_key_i;
        cnt_d   = l_cnt_i;
      end
    end else if (op_i.del && !lt_q) begin
      valid_d = r_valid_i;
      key_d   = r_key_i;
      cnt_d   = r_cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (upd_en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en_i) begin
      key_q <= key_d;
      cnt_q <= cnt_d;
    end
    if (cmp_en_i) begin
      lt_q <= valid_q && (key_q < cmp_key_i);
      gt_q <= valid_q && (key_q > cmp_key_i);
      eq_q <= valid_q && (key_q == cmp_key_i);
    end
  end

  assign valid_o     = valid_q;
  assign key_o       = key_q;
  assign cnt_o       = cnt_q;
  assign lt_o        = lt_q;
  assign gt_o        = gt_q;
  assign eq_o        = eq_q;
  // entries are sorted, so lt/gt form contiguous runs; the run edges are the neighbors
  assign sel_below_o = lt_q && !r_lt_i;
  assign sel_above_o = gt_q && !l_gt_i;
  assign cnt_one_o   = eq_q && (cnt_q == CNT_ONE);

endmodule
`default_nettype wire

// ===== hdl/ordered_multiset_neighbor_query.sv =====
// Ordered multiset with neighbor queries.
// Input channel: in_valid_i/in_stall_o with command_i and key_value_i.
// Output channel: out_valid_o/out_stall_i, one result per request.
// Config port: cfg_we_i writes cfg_data_i to the register at cfg_index_i
// (0 missing-below value, 1 missing-above value); write only while idle.
// Keys sit sorted in a chain of CAPACITY cells, each with a key, count and
// valid bit. On accept every cell compares its key with the request key;
// once the output register is free, the neighbor selection and the
// shift/count update happen in all cells at once and the result is loaded
// into the output register. A new request is taken only after the previous
// one has finished the compare-then-update sequence of the cell chain.
// The next request is taken while a result still waits in the output register.
// If out_stall_i holds, the pending update waits until the output register frees.
// Reset empties the table (all valid bits clear) and restores both registers
// to -1 and 100001; no clearing pass is needed.
`default_nettype none
`include "ordered_multiset_neighbor_query_macros.svh"
module ordered_multiset_neighbor_query import omnq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [VAL_W-1:0]      cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [CMD_W-1:0]      command_i,
  input  wire logic [KEY_BITS-1:0]   key_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [VAL_W-1:0]           below_key_o,
  output logic [VAL_W-1:0]           above_key_o,
  output logic                       has_below_o,
  output logic                       has_above_o,
  output logic                       was_present_o,
  output logic [COUNT_BITS-1:0]      count_after_o,
  output logic                       table_full_error_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RES  = 1'b1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  logic                  state_q, state_d;
  logic [CMD_W-1:0]      cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VAL_W-1:0]      miss_below_q, miss_above_q;

  logic                  accept, advance;
  cell_op_t              op;

  logic                  valid_w   [CAPACITY];
  logic [KEY_BITS-1:0]   key_w     [CAPACITY];
  logic [COUNT_BITS-1:0] cnt_w     [CAPACITY];
  logic                  lt_w      [CAPACITY];
  logic                  gt_w      [CAPACITY];
  logic                  eq_w      [CAPACITY];
  logic                  sbel_w    [CAPACITY];
  logic                  sabv_w    [CAPACITY];
  logic                  one_w     [CAPACITY];
  logic [CAPACITY-1:0]   valid_vec;

  logic                  any_eq, any_one, any_below, any_above, full;
  logic [KEY_BITS-1:0]   below_k, above_k;
  logic [COUNT_BITS-1:0] eq_cnt;
  logic [KEY_BITS+VAL_W-1:0] below_ext, above_ext;

  logic                  out_valid_q;
  logic [VAL_W-1:0]      below_q, above_q;
  logic                  hb_q, ha_q, pres_q, full_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [VAL_W-1:0]      below_d, above_d;
  logic                  hb_d, ha_d, pres_d, full_d;
  logic [COUNT_BITS-1:0] cnt_d;

  assign in_stall_o = (state_q == ST_RES);
  assign accept     = in_valid_i && !in_stall_o;
  assign advance    = (state_q == ST_RES) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_RES;
    end else if (advance) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      miss_below_q <= MISS_BELOW_RST;
      miss_above_q <= MISS_ABOVE_RST;
    end else begin
      state_q <= state_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MISS_BELOW: miss_below_q <= cfg_data_i;
          REG_MISS_ABOVE: miss_above_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      key_q <= key_value_i;
    end
    if (advance) begin
      below_q <= below_d;
      above_q <= above_d;
      hb_q    <= hb_d;
      ha_q    <= ha_d;
      pres_q  <= pres_d;
      cnt_q   <= cnt_d;
      full_q  <= full_d;
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  l_lt, l_gt, l_valid, r_lt, r_valid;
    logic [KEY_BITS-1:0]   l_key, r_key;
    logic [COUNT_BITS-1:0] l_cnt, r_cnt;

    if (i == 0) begin : g_first
      assign l_lt    = 1'b1;
      assign l_gt    = 1'b0;
      assign l_valid = 1'b0;
      assign l_key   = '0;
      assign l_cnt   = '0;
    end else begin : g_mid_l
      assign l_lt    = lt_w[i-1];
      assign l_gt    = gt_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_key   = key_w[i-1];
      assign l_cnt   = cnt_w[i-1];
    end

    if (i == CAPACITY-1) begin : g_last
      assign r_lt    = 1'b0;
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_cnt   = '0;
    end else begin : g_mid_r
      assign r_lt    = lt_w[i+1];
      assign r_valid = valid_w[i+1];
      assign r_key   = key_w[i+1];
      assign r_cnt   = cnt_w[i+1];
    end

    omnq_cell #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmp_en_i    (accept),
      .cmp_key_i   (key_value_i),
      .upd_en_i    (advance),
      .op_i        (op),
      .ins_key_i   (key_q),
      .l_lt_i      (l_lt),
      .l_gt_i      (l_gt),
      .l_valid_i   (l_valid),
      .l_key_i     (l_key),
      .l_cnt_i     (l_cnt),
      .r_lt_i      (r_lt),
      .r_valid_i   (r_valid),
      .r_key_i     (r_key),
      .r_cnt_i     (r_cnt),
      .valid_o     (valid_w[i]),
      .key_o       (key_w[i]),
      .cnt_o       (cnt_w[i]),
      .lt_o        (lt_w[i]),
      .gt_o        (gt_w[i]),
      .eq_o        (eq_w[i]),
      .sel_below_o (sbel_w[i]),
      .sel_above_o (sabv_w[i]),
      .cnt_one_o   (one_w[i])
    );

    assign valid_vec[i] = valid_w[i];
  end

  // one-hot gather of the selected cells
  always_comb begin
    any_eq    = 1'b0;
    any_one   = 1'b0;
    any_below = 1'b0;
    any_above = 1'b0;
    below_k   = '0;
    above_k   = '0;
    eq_cnt    = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq    = any_eq    | eq_w[i];
      any_one   = any_one   | one_w[i];
      any_below = any_below | sbel_w[i];
      any_above = any_above | sabv_w[i];
      below_k   = below_k | (key_w[i] & {KEY_BITS{sbel_w[i]}});
      above_k   = above_k | (key_w[i] & {KEY_BITS{sabv_w[i]}});
      eq_cnt    = eq_cnt  | (cnt_w[i] & {COUNT_BITS{eq_w[i]}});
    end
  end

  assign full      = valid_w[CAPACITY-1];
  assign below_ext = {{VAL_W{1'b0}}, below_k};
  assign above_ext = {{VAL_W{1'b0}}, above_k};

  always_comb begin
    op     = '0;
    op.ins = advance && (cmd_q == CMD_ADD) && !any_eq && !full;
    op.inc = advance && (cmd_q == CMD_ADD) && any_eq;
    op.dec = advance && (cmd_q == CMD_REMOVE) && any_eq && !any_one;
    op.del = advance && (cmd_q == CMD_REMOVE) && any_one;
    op.clr = advance && (cmd_q == CMD_CLEAR);
  end

  always_comb begin
    below_d = miss_below_q;
    above_d = miss_above_q;
    hb_d    = 1'b0;
    ha_d    = 1'b0;
    pres_d  = any_eq;
    cnt_d   = '0;
    full_d  = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        if (any_eq) begin
          cnt_d = (eq_cnt == CNT_MAX) ? eq_cnt : eq_cnt + CNT_ONE;
        end else if (full) begin
          full_d = 1'b1;
        end else begin
          cnt_d = CNT_ONE;
        end
      end
      CMD_REMOVE: begin
        if (any_eq && !any_one) begin
          cnt_d = eq_cnt - CNT_ONE;
        end
      end
      CMD_QUERY: begin
        cnt_d = eq_cnt;
        hb_d  = any_below;
        ha_d  = any_above;
        if (any_below) begin
          below_d = below_ext[VAL_W-1:0];
        end
        if (any_above) begin
          above_d = above_ext[VAL_W-1:0];
        end
      end
      CMD_CLEAR: begin
        pres_d = 1'b0;
      end
      default: ;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign below_key_o        = below_q;
  assign above_key_o        = above_q;
  assign has_below_o        = hb_q;
  assign has_above_o        = ha_q;
  assign was_present_o      = pres_q;
  assign count_after_o      = cnt_q;
  assign table_full_error_o = full_q;

  // occupied cells always form a prefix of the chain
  `OMNQ_ASSERT(a_valid_prefix, ((valid_vec >> 1) & ~valid_vec) == '0)
  `OMNQ_ASSERT_NEXT(a_clear_empties, advance && (cmd_q == CMD_CLEAR), valid_vec == '0)
  `OMNQ_ASSERT(a_full_err_clean, !(out_valid_q && full_q) || (!pres_q && cnt_q == '0))

endmodule
`default_nettype wire

// ===== sim/omnq_result_checker.sv =====
`default_nettype none
module omnq_result_checker import omnq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [VAL_W-1:0]      cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire logic [CMD_W-1:0]      command_i,
  input  wire logic [KEY_BITS-1:0]   key_value_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire logic [VAL_W-1:0]      below_key_i,
  input  wire logic [VAL_W-1:0]      above_key_i,
  input  wire logic                  has_below_i,
  input  wire logic                  has_above_i,
  input  wire logic                  was_present_i,
  input  wire logic [COUNT_BITS-1:0] count_after_i,
  input  wire logic                  table_full_error_i,
  output int                         outstanding_o,
  output int                         error_count_o,
  output int                         results_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [VAL_W-1:0]      below_key;
    logic [VAL_W-1:0]      above_key;
    logic                  has_below;
    logic                  has_above;
    logic                  was_present;
    logic [COUNT_BITS-1:0] count_after;
    logic                  table_full_error;
  } answer_t;

  // sorted shadow table: entries 0..table_used-1 hold distinct keys, ascending
  logic [KEY_BITS-1:0]   table_key   [CAPACITY];
  logic [COUNT_BITS-1:0] table_count [CAPACITY];
  int                    table_used    = 0;
  logic [VAL_W-1:0]      below_default = MISS_BELOW_RST;
  logic [VAL_W-1:0]      above_default = MISS_ABOVE_RST;

  answer_t awaited_answers [$];
  answer_t new_answer;
  answer_t oldest_answer;

  initial begin
    outstanding_o     = 0;
    error_count_o     = 0;
    results_checked_o = 0;
  end

  task automatic log_error(input string msg);
    error_count_o++;
    if (error_count_o <= MAX_PRINTED) begin
      $display("%0t ns omnq check: result %0d: %s", $time, results_checked_o, msg);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      log_error($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
    end
  endtask

  // Updates the shadow table for one request and returns what the block must answer.
  task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [KEY_BITS-1:0] key,
                               output answer_t ans);
    int   slot;
    int   upper;
    int   i;
    logic hit;
    ans           = '0;
    ans.below_key = below_default;
    ans.above_key = above_default;
    slot = 0;
    for (i = 0; i < table_used; i++) begin
      if (table_key[i] < key) slot++;
    end
    hit = (slot < table_used) && (table_key[slot] == key);
    case (cmd)
      CMD_ADD: begin
        ans.was_present = hit;
        if (hit) begin
          if (table_count[slot] != '1) begin
            table_count[slot] = table_count[slot] + COUNT_BITS'(1);
          end
          ans.count_after = table_count[slot];
        end else if (table_used >= CAPACITY) begin
          ans.table_full_error = 1'b1;
        end else begin
          for (i = table_used; i > slot; i--) begin
            table_key[i]   = table_key[i-1];
            table_count[i] = table_count[i-1];
          end
          table_key[slot]   = key;
          table_count[slot] = COUNT_BITS'(1);
          table_used++;
          ans.count_after = COUNT_BITS'(1);
        end
      end
      CMD_REMOVE: begin
        ans.was_present = hit;
        if (hit) begin
          if (table_count[slot] > COUNT_BITS'(1)) begin
            table_count[slot] = table_count[slot] - COUNT_BITS'(1);
            ans.count_after   = table_count[slot];
          end else begin
            for (i = slot; i + 1 < table_used; i++) begin
              table_key[i]   = table_key[i+1];
              table_count[i] = table_count[i+1];
            end
            table_used--;
          end
        end
      end
      CMD_QUERY: begin
        ans.was_present = hit;
        if (hit) ans.count_after = table_count[slot];
        if (slot > 0) begin
          ans.below_key = VAL_W'(table_key[slot-1]);
          ans.has_below = 1'b1;
        end
        // an exact match is skipped when looking upward
        upper = hit ? slot + 1 : slot;
        if (upper < table_used) begin
          ans.above_key = VAL_W'(table_key[upper]);
          ans.has_above = 1'b1;
        end
      end
      CMD_CLEAR: begin
        table_used = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_used    = 0;
      below_default = MISS_BELOW_RST;
      above_default = MISS_ABOVE_RST;
      awaited_answers.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MISS_BELOW: below_default = cfg_data_i;
          REG_MISS_ABOVE: above_default = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_answers.size() == 0) begin
          log_error("result with no request outstanding");
        end else begin
          oldest_answer = awaited_answers.pop_front();
          check_field("below_key", 32'(below_key_i), 32'(oldest_answer.below_key));
          check_field("above_key", 32'(above_key_i), 32'(oldest_answer.above_key));
          check_field("has_below", 32'(has_below_i), 32'(oldest_answer.has_below));
          check_field("has_above", 32'(has_above_i), 32'(oldest_answer.has_above));
          check_field("was_present", 32'(was_present_i), 32'(oldest_answer.was_present));
          check_field("count_after", 32'(count_after_i), 32'(oldest_answer.count_after));
          check_field("table_full_error", 32'(table_full_error_i),
                      32'(oldest_answer.table_full_error));
          results_checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(command_i, key_value_i, new_answer);
        awaited_answers.push_back(new_answer);
      end
      outstanding_o <= awaited_answers.size();
    end
  end

endmodule
`default_nettype wire

// ===== sim/ordered_multiset_neighbor_query_tb.sv =====
`default_nettype none
module ordered_multiset_neighbor_query_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import omnq_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_GAP      = 15;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 8;
  localparam int POOL_SIZE    = 96;
  localparam int REPEAT_ADDS  = 40;
  localparam logic [KEY_BITS_DEF-1:0] KEY_ONE    = KEY_BITS_DEF'(1);
  localparam logic [KEY_BITS_DEF-1:0] KEY_MAX    = '1;
  localparam logic [VAL_W-1:0]        VAL_ZERO   = '0;
  localparam logic [VAL_W-1:0]        VAL_TOP    = 22'd1048576;
  localparam logic [VAL_W-1:0]        VAL_MINUS1 = '1;

  typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_FULL} command_mix_e;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = REG_MISS_BELOW;
  logic [VAL_W-1:0]          cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic [CMD_W-1:0]          command_i   = CMD_QUERY;
  logic [KEY_BITS_DEF-1:0]   key_value_i = '0;
  logic                      out_stall_i = 1'b0;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic [VAL_W-1:0]          below_key_o;
  logic [VAL_W-1:0]          above_key_o;
  logic                      has_below_o;
  logic                      has_above_o;
  logic                      was_present_o;
  logic [COUNT_BITS_DEF-1:0] count_after_o;
  logic                      table_full_error_o;

  int outstanding;
  int error_count;
  int results_checked;

  bit tx_free = 1'b0;
  bit rx_free = 1'b0;
  int holds_requested = 0;
  int holds_done      = 0;
  int requests_sent   = 0;
  int clears_sent     = 0;
  int cycles          = 0;
  logic [KEY_BITS_DEF-1:0] key_pool [$];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  ordered_multiset_neighbor_query DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .key_value_i        (key_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .below_key_o        (below_key_o),
    .above_key_o        (above_key_o),
    .has_below_o        (has_below_o),
    .has_above_o        (has_above_o),
    .was_present_o      (was_present_o),
    .count_after_o      (count_after_o),
    .table_full_error_o (table_full_error_o)
  );

  omnq_result_checker result_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .command_i          (command_i),
    .key_value_i        (key_value_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .below_key_i        (below_key_o),
    .above_key_i        (above_key_o),
    .has_below_i        (has_below_o),
    .has_above_i        (has_above_o),
    .was_present_i      (was_present_o),
    .count_after_i      (count_after_o),
    .table_full_error_i (table_full_error_o),
    .outstanding_o      (outstanding),
    .error_count_o      (error_count),
    .results_checked_o  (results_checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests still unanswered", cycles, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_BITS_DEF-1:0] key);
    int gap;
    gap = tx_free ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    key_value_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
    if (cmd == CMD_ADD) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_SIZE) void'(key_pool.pop_front());
    end
  endtask

  task automatic wait_all_answered();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  // registers change only with the block idle
  task automatic set_missing_values(input logic [VAL_W-1:0] below, input logic [VAL_W-1:0] above);
    wait_all_answered();
    repeat (SETTLE) @(posedge clk_i);
    write_reg(REG_MISS_BELOW, below);
    write_reg(REG_MISS_ABOVE, above);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] draw_missing_value();
    int v;
    v = int'($urandom_range(0, 1048577)) - 1;
    return VAL_W'(v);
  endfunction

  // mostly keys already used, their neighbors and the extremes
  function automatic logic [KEY_BITS_DEF-1:0] pick_key();
    int r;
    logic [KEY_BITS_DEF-1:0] k;
    r = $urandom_range(0, 99);
    if (key_pool.size() > 0 && r < 60) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r >= 45) k = r[0] ? k + KEY_ONE : k - KEY_ONE;
    end else if (r < 70) begin
      case (r % 4)
        0:       k = '0;
        1:       k = KEY_ONE;
        2:       k = KEY_MAX - KEY_ONE;
        default: k = KEY_MAX;
      endcase
    end else begin
      k = KEY_BITS_DEF'($urandom());
    end
    return k;
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input command_mix_e mix);
    int r;
    int add_lim;
    int remove_lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW:     begin add_lim = 55; remove_lim = 65; end
      MIX_BALANCED: begin add_lim = 35; remove_lim = 65; end
      MIX_SHRINK:   begin add_lim = 15; remove_lim = 65; end
      default:      begin add_lim = 45; remove_lim = 55; end
    endcase
    if (r < add_lim) return CMD_ADD;
    if (r < remove_lim) return CMD_REMOVE;
    if (r == 99 && mix != MIX_FULL) return CMD_CLEAR;
    return CMD_QUERY;
  endfunction

  task automatic run_mix(input int count, input command_mix_e mix, input int hold_at,
                         input int pause_at);
    int i;
    logic [CMD_W-1:0] cmd;
    for (i = 0; i < count; i++) begin
      if (i == hold_at) holds_requested++;
      if (i == pause_at) wait_all_answered();
      cmd = pick_command(mix);
      send_request(cmd, pick_key());
    end
  endtask

  // result side: random stall per result, one long hold when asked
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (holds_requested > holds_done) begin
        holds_done++;
        stall = LONG_HOLD;
      end else begin
        stall = rx_free ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [KEY_BITS_DEF-1:0] count_key;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, count up/down, delete of the lowest entry, clear
    send_request(CMD_QUERY, '0);
    send_request(CMD_REMOVE, KEY_BITS_DEF'(7));
    send_request(CMD_ADD, '0);
    send_request(CMD_ADD, KEY_MAX);
    send_request(CMD_ADD, KEY_BITS_DEF'(500));
    send_request(CMD_QUERY, KEY_BITS_DEF'(500));
    send_request(CMD_QUERY, '0);
    send_request(CMD_QUERY, KEY_MAX);
    send_request(CMD_QUERY, KEY_BITS_DEF'(250));
    send_request(CMD_ADD, KEY_BITS_DEF'(500));
    send_request(CMD_QUERY, KEY_BITS_DEF'(500));
    send_request(CMD_REMOVE, KEY_BITS_DEF'(500));
    send_request(CMD_REMOVE, KEY_BITS_DEF'(500));
    send_request(CMD_REMOVE, KEY_BITS_DEF'(500));
    send_request(CMD_QUERY, KEY_BITS_DEF'(500));
    send_request(CMD_REMOVE, '0);
    send_request(CMD_QUERY, KEY_MAX);
    send_request(CMD_CLEAR, KEY_MAX);
    send_request(CMD_QUERY, KEY_ONE);
    send_request(CMD_ADD, KEY_ONE);

    // reset defaults, table grows; long result-side hold halfway
    run_mix(270, MIX_GROW, 135, -1);

    set_missing_values(VAL_ZERO, VAL_TOP);
    tx_free = 1'b1;
    rx_free = 1'b1;
    run_mix(270, MIX_BALANCED, -1, -1);

    // fill the table, then keep it near full so new keys get dropped
    set_missing_values(VAL_TOP, VAL_MINUS1);
    tx_free = 1'b0;
    rx_free = 1'b0;
    send_request(CMD_CLEAR, KEY_BITS_DEF'($urandom()));
    repeat (70) send_request(CMD_ADD, KEY_BITS_DEF'($urandom()));
    run_mix(230, MIX_FULL, -1, -1);

    set_missing_values(draw_missing_value(), draw_missing_value());
    rx_free = 1'b1;
    run_mix(270, MIX_SHRINK, -1, 90);

    // a run of adds on a single key, back to back
    set_missing_values(draw_missing_value(), draw_missing_value());
    tx_free = 1'b1;
    count_key = KEY_BITS_DEF'($urandom());
    send_request(CMD_CLEAR, count_key);
    repeat (REPEAT_ADDS) send_request(CMD_ADD, count_key);
    send_request(CMD_QUERY, count_key);
    send_request(CMD_REMOVE, count_key);
    send_request(CMD_QUERY, count_key + KEY_ONE);
    key_pool.delete();
    key_pool.push_back(count_key);

    set_missing_values(draw_missing_value(), draw_missing_value());
    rx_free = 1'b0;
    run_mix(270, MIX_BALANCED, -1, -1);

    wait_all_answered();
    repeat (SETTLE) @(posedge clk_i);

    $display("Run covered %0d requests (%0d clears) under six register settings,",
             requests_sent, clears_sent);
    $display("a full table, %0d adds on one key and back-pressure; %0d results checked.",
             REPEAT_ADDS, results_checked);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
